>>> rtl/smi_pkg.sv
// Shared types and constants for the small matrix inverse core.
`timescale 1ns / 1ps
package smi_pkg;

   localparam int FRAC_BITS = 16;
   localparam int ENT_W     = 32;
   localparam int LANES     = 9;
   localparam int ADJ_W     = 2 * ENT_W;
   localparam int DET_W     = 3 * ENT_W + 1;
   localparam int DMAG_W    = DET_W - 1;
   localparam int QB        = ENT_W + 1;
   localparam int NUM_W     = ADJ_W + 2 * FRAC_BITS;
   localparam int RW        = (NUM_W > DMAG_W + QB) ? NUM_W : DMAG_W + QB;
   localparam int QDEPTH    = 4;
   localparam int QA_W      = $clog2(QDEPTH);

   typedef struct packed {
      logic                    mode;
      logic signed [ENT_W-1:0] a00;
      logic signed [ENT_W-1:0] a01;
      logic signed [ENT_W-1:0] a02;
      logic signed [ENT_W-1:0] a10;
      logic signed [ENT_W-1:0] a11;
      logic signed [ENT_W-1:0] a12;
      logic signed [ENT_W-1:0] a20;
      logic signed [ENT_W-1:0] a21;
      logic signed [ENT_W-1:0] a22;
   } smi_req_type;

   typedef struct packed {
      logic signed [ENT_W-1:0] inv00;
      logic signed [ENT_W-1:0] inv01;
      logic signed [ENT_W-1:0] inv02;
      logic signed [ENT_W-1:0] inv10;
      logic signed [ENT_W-1:0] inv11;
      logic signed [ENT_W-1:0] inv12;
      logic signed [ENT_W-1:0] inv20;
      logic signed [ENT_W-1:0] inv21;
      logic signed [ENT_W-1:0] inv22;
      logic                    singular;
      logic                    saturated;
   } smi_rsp_type;

   typedef struct packed {
      logic                          singular;
      logic                          dneg;
      logic [DMAG_W-1:0]             dmag;
      logic [LANES-1:0][ADJ_W-1:0]   adj;
   } smi_work_type;

   typedef struct packed {
      logic                          singular;
      logic [DMAG_W-1:0]             dmag;
      logic [LANES-1:0]              neg;
      logic [LANES-1:0]              ovf;
      logic [LANES-1:0][RW-1:0]      rem;
      logic [LANES-1:0][QB-1:0]      q;
   } smi_dstage_type;

   typedef struct packed {
      logic                          singular;
      logic [LANES-1:0]              neg;
      logic [LANES-1:0]              ovf;
      logic [LANES-1:0][QB:0]        qr;
   } smi_round_type;

endpackage

>>> rtl/smi_front.sv
// Front end: adjugate, determinant and singular classification pipeline.
`timescale 1ns / 1ps
module smi_front import smi_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  smi_req_type  req_data,
   input  logic         q_full,
   output logic         push,
   output smi_work_type push_data
);

   localparam int NST = 6;

   logic [NST-1:0] vld_ff;
   logic           en;

   logic signed [ENT_W-1:0] m [LANES];
   logic signed [ADJ_W-1:0] prod_in [2*LANES];
   logic signed [ADJ_W-1:0] prod_ff [2*LANES];
   logic signed [ENT_W-1:0] dm1_in [3];
   logic signed [ENT_W-1:0] dm1_ff [3];
   logic                    mode_ff;

   logic [LANES-1:0][ADJ_W-1:0] adj2_in, adj2_ff, adj3_ff, adj4_ff, adj5_ff;
   logic signed [ENT_W-1:0]     dm2_ff [3];

   logic signed [ADJ_W-1:0]   ph_in [3];
   logic signed [ADJ_W-1:0]   ph_ff [3];
   logic signed [ADJ_W:0]     pl_in [3];
   logic signed [ADJ_W:0]     pl_ff [3];
   logic signed [DET_W-1:0]   term_in [3];
   logic signed [DET_W-1:0]   term_ff [3];
   logic signed [DET_W-1:0]   det_in, det_ff;
   smi_work_type              work_in, work_ff;

   assign en        = !vld_ff[NST-1] || !q_full;
   assign req_ready = en;
   assign push      = vld_ff[NST-1];
   assign push_data = work_ff;

   // 2x2 folds into the 3x3 formulas: unused entries zero, a22 forced to one
   always_comb begin
      m[0] = req_data.a00;
      m[1] = req_data.a01;
      m[3] = req_data.a10;
      m[4] = req_data.a11;
      if (req_data.mode) begin
         m[2] = req_data.a02;
         m[5] = req_data.a12;
         m[6] = req_data.a20;
         m[7] = req_data.a21;
         m[8] = req_data.a22;
      end else begin
         m[2] = '0;
         m[5] = '0;
         m[6] = '0;
         m[7] = '0;
         m[8] = ENT_W'(1);
      end
      prod_in[0]  = m[4] * m[8];
      prod_in[1]  = m[5] * m[7];
      prod_in[2]  = m[2] * m[7];
      prod_in[3]  = m[1] * m[8];
      prod_in[4]  = m[1] * m[5];
      prod_in[5]  = m[2] * m[4];
      prod_in[6]  = m[5] * m[6];
      prod_in[7]  = m[3] * m[8];
      prod_in[8]  = m[0] * m[8];
      prod_in[9]  = m[2] * m[6];
      prod_in[10] = m[2] * m[3];
      prod_in[11] = m[0] * m[5];
      prod_in[12] = m[3] * m[7];
      prod_in[13] = m[4] * m[6];
      prod_in[14] = m[1] * m[6];
      prod_in[15] = m[0] * m[7];
      prod_in[16] = m[0] * m[4];
      prod_in[17] = m[1] * m[3];
      dm1_in[0] = m[0];
      dm1_in[1] = m[1];
      dm1_in[2] = m[2];
   end

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         adj2_in[k] = prod_ff[2*k] - prod_ff[2*k+1];
      end
      if (!mode_ff) begin
         adj2_in[8] = '0;
      end
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         ph_in[j] = dm2_ff[j] * $signed(adj2_ff[3*j][ADJ_W-1:ENT_W]);
         pl_in[j] = dm2_ff[j] * $signed({1'b0, adj2_ff[3*j][ENT_W-1:0]});
         term_in[j] = (DET_W'(ph_ff[j]) <<< ENT_W) + DET_W'(pl_ff[j]);
      end
      det_in = term_ff[0] + term_ff[1] + term_ff[2];
      work_in.singular = (det_ff == '0);
      work_in.dneg     = det_ff[DET_W-1];
      work_in.dmag     = det_ff[DET_W-1] ? DMAG_W'(-det_ff) : DMAG_W'(det_ff);
      work_in.adj      = adj5_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         dm1_ff  <= dm1_in;
         mode_ff <= req_data.mode;
         adj2_ff <= adj2_in;
         dm2_ff  <= dm1_ff;
         ph_ff   <= ph_in;
         pl_ff   <= pl_in;
         adj3_ff <= adj2_ff;
         term_ff <= term_in;
         adj4_ff <= adj3_ff;
         det_ff  <= det_in;
         adj5_ff <= adj4_ff;
         work_ff <= work_in;
      end
   end

endmodule

>>> rtl/smi_queue.sv
// Short queue between front end and divider back end.
`timescale 1ns / 1ps
module smi_queue import smi_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  smi_work_type push_data,
   output logic         full,
   input  logic         pop,
   output smi_work_type pop_data,
   output logic         empty
);

   smi_work_type   mem_ff [QDEPTH];
   logic [QA_W-1:0] wr_ff, rd_ff;
   logic [QA_W:0]   cnt_ff;
   logic            do_push, do_pop;

   assign full     = (cnt_ff == (QA_W+1)'(QDEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + 1'b1;
         if (do_pop)  rd_ff <= rd_ff + 1'b1;
         if (do_push && !do_pop) cnt_ff <= cnt_ff + 1'b1;
         else if (do_pop && !do_push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_data;
   end

endmodule

>>> rtl/smi_div.sv
// Back end: pipelined restoring division, rounding and saturation per entry.
`timescale 1ns / 1ps
module smi_div import smi_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_empty,
   input  smi_work_type pop_data,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output smi_rsp_type  rsp_data
);

   localparam int NV = QB + 3;
   localparam logic [QB:0] LIM_POS = (QB+1)'((64'd1 << (ENT_W-1)) - 1);
   localparam logic [QB:0] LIM_NEG = (QB+1)'(64'd1 << (ENT_W-1));

   logic [NV-1:0]   vld_ff;
   logic            en;
   smi_dstage_type  stage_in [QB+1];
   smi_dstage_type  stage_ff [QB+1];
   smi_round_type   rnd_in, rnd_ff;
   smi_rsp_type     out_in, out_ff;

   logic [ADJ_W-1:0]   mag;
   logic [RW:0]        diff;
   logic [QB:0]        lim, val;
   logic [ENT_W-1:0]   res [LANES];
   logic               sat;

   assign en        = !vld_ff[NV-1] || rsp_ready;
   assign pop       = en && !q_empty;
   assign rsp_valid = vld_ff[NV-1];
   assign rsp_data  = out_ff;

   always_comb begin
      mag  = '0;
      diff = '0;
      // first stage: magnitudes, scaled numerators, quotient overflow check
      stage_in[0].singular = pop_data.singular;
      stage_in[0].dmag     = pop_data.dmag;
      stage_in[0].q        = '0;
      for (int l = 0; l < LANES; l++) begin
         mag = pop_data.adj[l][ADJ_W-1] ? -pop_data.adj[l] : pop_data.adj[l];
         stage_in[0].neg[l] = pop_data.adj[l][ADJ_W-1] ^ pop_data.dneg;
         stage_in[0].rem[l] = RW'(mag) << (2 * FRAC_BITS);
         stage_in[0].ovf[l] = (RW'(mag) << (2 * FRAC_BITS)) >= (RW'(pop_data.dmag) << QB);
      end
      // one quotient bit per stage, most significant first
      for (int s = 1; s <= QB; s++) begin
         stage_in[s] = stage_ff[s-1];
         for (int l = 0; l < LANES; l++) begin
            diff = {1'b0, stage_ff[s-1].rem[l]} - {1'b0, RW'(stage_ff[s-1].dmag) << (QB-s)};
            if (!diff[RW]) begin
               stage_in[s].rem[l]       = diff[RW-1:0];
               stage_in[s].q[l][QB-s]   = 1'b1;
            end
         end
      end
   end

   always_comb begin
      rnd_in.singular = stage_ff[QB].singular;
      rnd_in.neg      = stage_ff[QB].neg;
      rnd_in.ovf      = stage_ff[QB].ovf;
      for (int l = 0; l < LANES; l++) begin
         rnd_in.qr[l] = {1'b0, stage_ff[QB].q[l]}
            + (QB+1)'({stage_ff[QB].rem[l][DMAG_W-1:0], 1'b0}
                      >= {1'b0, stage_ff[QB].dmag});
      end
   end

   always_comb begin
      sat = 1'b0;
      lim = '0;
      val = '0;
      for (int l = 0; l < LANES; l++) begin
         lim = rnd_ff.neg[l] ? LIM_NEG : LIM_POS;
         if (rnd_ff.ovf[l] || rnd_ff.qr[l] > lim) begin
            val = lim;
            sat = 1'b1;
         end else begin
            val = rnd_ff.qr[l];
         end
         res[l] = rnd_ff.neg[l] ? -val[ENT_W-1:0] : val[ENT_W-1:0];
         if (rnd_ff.singular) res[l] = '0;
      end
      out_in.inv00     = res[0];
      out_in.inv01     = res[1];
      out_in.inv02     = res[2];
      out_in.inv10     = res[3];
      out_in.inv11     = res[4];
      out_in.inv12     = res[5];
      out_in.inv20     = res[6];
      out_in.inv21     = res[7];
      out_in.inv22     = res[8];
      out_in.singular  = rnd_ff.singular;
      out_in.saturated = sat && !rnd_ff.singular;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NV-2:0], pop};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
         rnd_ff   <= rnd_in;
         out_ff   <= out_in;
      end
   end

endmodule

>>> rtl/small_matrix_inverse_core.sv
// Throughput: one matrix per cycle while rsp_ready holds; every stage of both pipelines is fully registered.
// The 33-stage restoring divider (one quotient bit per stage, nine lanes) sets the depth.
// A 4-beat queue lets the front end keep taking beats while the rsp side stalls.
// Reset (synchronous, active high) clears all valid bits and the queue pointers.
`timescale 1ns / 1ps
module small_matrix_inverse_core import smi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  smi_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output smi_rsp_type rsp_data
);

   logic         push, q_full, pop, q_empty;
   smi_work_type push_data, pop_data;

   smi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (push),
      .push_data (push_data)
   );

   smi_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   smi_div u_div (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
